[sv/pps_pkg.sv]
// shared types and constants for the preemptive priority scheduler
package pps_pkg;

  localparam int MAX_TASKS_DEF = 16;
  localparam int TIME_BITS_DEF = 16;

  localparam int ARR_W  = 16;
  localparam int BURST_W = 16;
  localparam int PRIO_W = 8;
  localparam int RESP_W = 16;
  localparam int ID_W   = 5;
  localparam int OUT_TIME_W = 16;

  localparam int MODE_W = 2;
  localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_TICK  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 72;

  typedef struct packed {
    logic [ARR_W-1:0]   arrival;
    logic [BURST_W-1:0] burst;
    logic [PRIO_W-1:0]  prio;
    logic [BURST_W-1:0] remaining;
    logic               started;
    logic [RESP_W-1:0]  response;
  } entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FIX,
    ST_REPORT
  } state_t;

endpackage

[sv/preemptive_priority_scheduler.sv]
// preemptive priority scheduler: task table in one memory, scanned once per tick
// load, clear and unused-mode requests are taken in idle and leave the sequencer idle
// a tick request reads slots 0 to loaded_count-1 one per cycle; its result is registered
// after the scan, fix and report states, and the next request is taken once the sequencer
// is back in idle; a result not yet taken by m_axis_tready holds the sequencer back
// rst clears the counters, sequencer and output valid; the table memory and output data are not cleared
module preemptive_priority_scheduler #(
  parameter int MAX_TASKS = pps_pkg::MAX_TASKS_DEF,
  parameter int TIME_BITS = pps_pkg::TIME_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // arrival, burst, prio_level
  input  logic [pps_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // mode
  input  logic [pps_pkg::MODE_W-1:0]     s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // ran_valid, ran_id, finished, completion_time, turnaround, waiting, response, all_done
  output logic [pps_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

  localparam int SLOT_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CNT_W  = $clog2(MAX_TASKS + 1);
  localparam int CALC_W = (TIME_BITS > pps_pkg::ARR_W) ? TIME_BITS : pps_pkg::ARR_W;
  localparam int IDX_W  = pps_pkg::ID_W + CNT_W;
  localparam logic [pps_pkg::BURST_W-1:0] BURST_ONE = pps_pkg::BURST_W'(1);

  pps_pkg::state_t state, state_next;

  pps_pkg::entry_t mem [MAX_TASKS];
  pps_pkg::entry_t mem_q;
  pps_pkg::entry_t mem_wdata;
  logic [SLOT_W-1:0] mem_waddr;
  logic              mem_we;

  logic [TIME_BITS-1:0] tick;
  logic [CNT_W-1:0]     loaded_count;
  logic [CNT_W-1:0]     completed_count;
  logic [CNT_W-1:0]     completed_next;

  logic [CNT_W-1:0]  rd_idx;
  logic              rd_pend;
  logic [SLOT_W-1:0] pend_slot;
  logic              issue;

  logic              found;
  logic [SLOT_W-1:0] best_slot;
  pps_pkg::entry_t   best;
  logic              better;

  logic [TIME_BITS-1:0] comp;
  logic [CALC_W-1:0]    tat;

  logic                    in_acc;
  logic                    adv;
  logic                    fin;
  logic [CALC_W-1:0]       wt;
  logic [CALC_W-1:0]       resp_now;
  logic [IDX_W-1:0]        id_wide;
  logic [CALC_W-1:0]       comp_wide;
  pps_pkg::entry_t         upd;

  logic [pps_pkg::ARR_W-1:0]   in_arrival;
  logic [pps_pkg::BURST_W-1:0] in_burst;
  logic [pps_pkg::PRIO_W-1:0]  in_prio;

  assign in_arrival = s_axis_tdata[15:0];
  assign in_burst   = s_axis_tdata[31:16];
  assign in_prio    = s_axis_tdata[39:32];
  assign in_acc     = s_axis_tvalid && s_axis_tready;

  // scan compare on returning read data
  assign issue  = (state == pps_pkg::ST_SCAN) && (rd_idx < loaded_count);
  assign better = (CALC_W'(mem_q.arrival) <= CALC_W'(tick)) && (mem_q.remaining != '0) &&
                  (!found || (mem_q.prio < best.prio) ||
                   ((mem_q.prio == best.prio) && (mem_q.arrival < best.arrival)));

  // report stage
  assign adv       = (state == pps_pkg::ST_REPORT) && (!m_axis_tvalid || m_axis_tready);
  assign fin       = found && (best.remaining == BURST_ONE);
  assign wt        = (tat >= CALC_W'(best.burst)) ? (tat - CALC_W'(best.burst)) : '0;
  assign resp_now  = CALC_W'(tick) - CALC_W'(best.arrival);
  assign id_wide   = IDX_W'(best_slot) + IDX_W'(1);
  assign comp_wide = CALC_W'(comp);
  assign completed_next = completed_count + CNT_W'(fin);

  always_comb begin
    upd = best;
    upd.remaining = best.remaining - BURST_ONE;
    upd.started = 1'b1;
    if (!best.started) begin
      upd.response = resp_now[pps_pkg::RESP_W-1:0];
    end
  end

  // write port mux
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = best_slot;
    mem_wdata = upd;
    if (state == pps_pkg::ST_IDLE) begin
      mem_we    = in_acc && (s_axis_tuser == pps_pkg::MODE_LOAD) &&
                  (loaded_count < CNT_W'(MAX_TASKS));
      mem_waddr = loaded_count[SLOT_W-1:0];
      mem_wdata.arrival   = in_arrival;
      mem_wdata.burst     = in_burst;
      mem_wdata.prio      = in_prio;
      mem_wdata.remaining = in_burst;
      mem_wdata.started   = 1'b0;
      mem_wdata.response  = '0;
    end else if (adv) begin
      mem_we = found;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_q <= mem[rd_idx[SLOT_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pps_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    s_axis_tready = 1'b0;
    unique case (state)
      pps_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid && (s_axis_tuser == pps_pkg::MODE_TICK)) begin
          state_next = pps_pkg::ST_SCAN;
        end
      end
      pps_pkg::ST_SCAN: begin
        if (!issue && !rd_pend) begin
          state_next = pps_pkg::ST_FIX;
        end
      end
      pps_pkg::ST_FIX: begin
        state_next = pps_pkg::ST_REPORT;
      end
      pps_pkg::ST_REPORT: begin
        if (adv) begin
          state_next = pps_pkg::ST_IDLE;
        end
      end
      default: state_next = pps_pkg::ST_IDLE;
    endcase
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state == pps_pkg::ST_IDLE) begin
      rd_idx <= '0;
    end else if (issue) begin
      rd_idx <= rd_idx + CNT_W'(1);
    end
    pend_slot <= rd_idx[SLOT_W-1:0];
    if (rd_pend && better) begin
      best      <= mem_q;
      best_slot <= pend_slot;
    end
    if (state == pps_pkg::ST_FIX) begin
      comp <= (tick == '1) ? tick : tick + TIME_BITS'(1);
      tat  <= ((tick == '1) ? CALC_W'(tick) : CALC_W'(tick) + CALC_W'(1)) -
              CALC_W'(best.arrival);
    end
    if (adv) begin
      m_axis_tdata <= {completed_next == loaded_count,
                       fin ? upd.response : {pps_pkg::RESP_W{1'b0}},
                       fin ? wt[pps_pkg::OUT_TIME_W-1:0] : {pps_pkg::OUT_TIME_W{1'b0}},
                       fin ? tat[pps_pkg::OUT_TIME_W-1:0] : {pps_pkg::OUT_TIME_W{1'b0}},
                       fin ? comp_wide[pps_pkg::OUT_TIME_W-1:0] :
                             {pps_pkg::OUT_TIME_W{1'b0}},
                       fin,
                       found ? id_wide[pps_pkg::ID_W-1:0] : {pps_pkg::ID_W{1'b0}},
                       found};
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      tick            <= '0;
      loaded_count    <= '0;
      completed_count <= '0;
      rd_pend         <= 1'b0;
      found           <= 1'b0;
      m_axis_tvalid   <= 1'b0;
    end else begin
      rd_pend <= issue;
      if (adv) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      if (state == pps_pkg::ST_IDLE) begin
        found <= 1'b0;
        if (in_acc) begin
          unique case (s_axis_tuser)
            pps_pkg::MODE_LOAD: begin
              if (loaded_count < CNT_W'(MAX_TASKS)) begin
                loaded_count <= loaded_count + CNT_W'(1);
              end
            end
            pps_pkg::MODE_CLEAR: begin
              loaded_count    <= '0;
              completed_count <= '0;
              tick            <= '0;
            end
            default: ;
          endcase
        end
      end else if (rd_pend && better) begin
        found <= 1'b1;
      end
      if (adv) begin
        completed_count <= completed_next;
        tick            <= comp;
      end
    end
  end

  a_no_write_in_scan: assert property (@(posedge clk) disable iff (rst)
    (state == pps_pkg::ST_SCAN) |-> !mem_we)
    else $error("table written during scan");

  a_count_order: assert property (@(posedge clk) disable iff (rst)
    completed_count <= loaded_count)
    else $error("more tasks completed than loaded");

  a_pend_in_scan: assert property (@(posedge clk) disable iff (rst)
    rd_pend |-> (state == pps_pkg::ST_SCAN))
    else $error("read data returned outside scan");

  a_tick_moves_once: assert property (@(posedge clk) disable iff (rst)
    (state == pps_pkg::ST_SCAN) |=> $stable(tick))
    else $error("tick counter changed during scan");

endmodule

[bench/tb.sv]
// self-checking testbench for the preemptive priority scheduler stream block
`timescale 1ns / 100ps

module tb;

  localparam logic [pps_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES = 40;
  localparam int RANDOM_ITEMS = 1700;

  // one tick report, ran_valid in the lowest bit
  typedef struct packed {
    logic                           all_done;
    logic [pps_pkg::OUT_TIME_W-1:0] response;
    logic [pps_pkg::OUT_TIME_W-1:0] waiting;
    logic [pps_pkg::OUT_TIME_W-1:0] turnaround;
    logic [pps_pkg::OUT_TIME_W-1:0] completion_time;
    logic                           finished;
    logic [pps_pkg::ID_W-1:0]       ran_id;
    logic                           ran_valid;
  } tick_report_t;

  class sched_scoreboard;
    bit [pps_pkg::ARR_W-1:0]   arrival_of[pps_pkg::MAX_TASKS_DEF];
    bit [pps_pkg::BURST_W-1:0] burst_of[pps_pkg::MAX_TASKS_DEF];
    bit [pps_pkg::PRIO_W-1:0]  prio_of[pps_pkg::MAX_TASKS_DEF];
    bit [pps_pkg::BURST_W-1:0] work_left[pps_pkg::MAX_TASKS_DEF];
    bit                        has_run[pps_pkg::MAX_TASKS_DEF];
    bit [pps_pkg::RESP_W-1:0]  first_run[pps_pkg::MAX_TASKS_DEF];
    bit [pps_pkg::OUT_TIME_W-1:0] now_tick;
    int loaded;
    int completed;
    tick_report_t pending_reports[$];
    int errors;
    int n_load, n_tick, n_clear, n_other, n_finished, n_checked;

    function int pending();
      return pending_reports.size();
    endfunction

    function tick_report_t schedule_tick();
      tick_report_t r;
      bit found;
      int win;
      int id_num;
      bit [pps_pkg::OUT_TIME_W-1:0] done_at;
      bit [pps_pkg::OUT_TIME_W-1:0] span;
      r = '0;
      found = 0;
      win = 0;
      for (int i = 0; i < loaded; i++) begin
        if (arrival_of[i] <= now_tick && work_left[i] != 0) begin
          if (!found || prio_of[i] < prio_of[win] ||
              (prio_of[i] == prio_of[win] && arrival_of[i] < arrival_of[win])) begin
            win = i;
            found = 1;
          end
        end
      end
      if (found) begin
        r.ran_valid = 1'b1;
        id_num = win + 1;
        r.ran_id = id_num[pps_pkg::ID_W-1:0];
        if (!has_run[win]) begin
          first_run[win] = now_tick - arrival_of[win];
          has_run[win] = 1'b1;
        end
        work_left[win]--;
        if (work_left[win] == 0) begin
          done_at = (now_tick == '1) ? now_tick : now_tick + 1'b1;
          span = done_at - arrival_of[win];
          completed++;
          n_finished++;
          r.finished = 1'b1;
          r.completion_time = done_at;
          r.turnaround = span;
          r.waiting = (span >= burst_of[win]) ? span - burst_of[win] : '0;
          r.response = first_run[win];
        end
      end
      if (now_tick != '1) now_tick++;
      r.all_done = (completed == loaded);
      return r;
    endfunction

    function void note_request(bit [pps_pkg::MODE_W-1:0] mode, bit [pps_pkg::ARR_W-1:0] arr,
                               bit [pps_pkg::BURST_W-1:0] bst,
                               bit [pps_pkg::PRIO_W-1:0] pr);
      case (mode)
        pps_pkg::MODE_LOAD: begin
          n_load++;
          if (loaded < pps_pkg::MAX_TASKS_DEF) begin
            arrival_of[loaded] = arr;
            burst_of[loaded] = bst;
            prio_of[loaded] = pr;
            work_left[loaded] = bst;
            has_run[loaded] = 1'b0;
            first_run[loaded] = '0;
            loaded++;
          end
        end
        pps_pkg::MODE_CLEAR: begin
          n_clear++;
          loaded = 0;
          completed = 0;
          now_tick = '0;
        end
        pps_pkg::MODE_TICK: begin
          n_tick++;
          pending_reports.push_back(schedule_tick());
        end
        default: n_other++;
      endcase
    endfunction

    function void compare_field(string field, longint unsigned want, longint unsigned got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", field, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic [pps_pkg::OUT_DATA_W-1:0] data);
      tick_report_t got;
      tick_report_t want;
      got = data;
      if (pending_reports.size() == 0) begin
        $error("tick report with none outstanding: %h", data);
        errors++;
        return;
      end
      want = pending_reports.pop_front();
      n_checked++;
      compare_field("ran_valid", want.ran_valid, got.ran_valid);
      compare_field("ran_id", want.ran_id, got.ran_id);
      compare_field("finished", want.finished, got.finished);
      compare_field("completion_time", want.completion_time, got.completion_time);
      compare_field("turnaround", want.turnaround, got.turnaround);
      compare_field("waiting", want.waiting, got.waiting);
      compare_field("response", want.response, got.response);
      compare_field("all_done", want.all_done, got.all_done);
    endfunction
  endclass

  logic clk;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [pps_pkg::IN_DATA_W-1:0] s_tdata = '0;
  logic [pps_pkg::MODE_W-1:0] s_tuser = pps_pkg::MODE_TICK;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [pps_pkg::OUT_DATA_W-1:0] m_tdata;

  sched_scoreboard sb = new();
  int src_idle_pct = 22;
  int sink_idle_pct = 77;
  int hold_requests = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int stall_cycles = 0;
  int sent_items = 0;

  preemptive_priority_scheduler dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_tvalid),
    .s_axis_tready(s_tready),
    .s_axis_tdata(s_tdata),
    .s_axis_tuser(s_tuser),
    .m_axis_tvalid(m_tvalid),
    .m_axis_tready(m_tready),
    .m_axis_tdata(m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // receiver: random stalls plus a long hold-off whenever hold_requests changes
  always @(posedge clk) begin
    if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_seen != hold_requests) begin
      hold_seen <= hold_requests;
      hold_left <= HOLD_CYCLES;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata);
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("timeout after %0d cycles without a handshake", stall_cycles);
      $display("Regression FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic send_request(input logic [pps_pkg::MODE_W-1:0] mode,
                              input logic [pps_pkg::ARR_W-1:0] arr,
                              input logic [pps_pkg::BURST_W-1:0] bst,
                              input logic [pps_pkg::PRIO_W-1:0] pr);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= mode;
    s_tdata <= {pr, bst, arr};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_request(mode, arr, bst, pr);
    if (mode != MODE_UNUSED) sent_items++;
  endtask

  // request whose data fields carry random don't-care bits
  task automatic send_random(input logic [pps_pkg::MODE_W-1:0] mode);
    logic [31:0] rnd_a;
    logic [31:0] rnd_b;
    rnd_a = $urandom;
    rnd_b = $urandom;
    send_request(mode, rnd_a[pps_pkg::ARR_W-1:0], rnd_b[pps_pkg::BURST_W-1:0],
                 rnd_a[31:32-pps_pkg::PRIO_W]);
  endtask

  task automatic send_tick();
    send_random(pps_pkg::MODE_TICK);
  endtask

  task automatic send_clear();
    send_random(pps_pkg::MODE_CLEAR);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic set_idle_mix();
    if (sent_items < RANDOM_ITEMS / 3) begin
      src_idle_pct = 22;
      sink_idle_pct <= 77;
    end else if (sent_items < 2 * RANDOM_ITEMS / 3) begin
      src_idle_pct = 77;
      sink_idle_pct <= 22;
    end else begin
      src_idle_pct = 0;
      sink_idle_pct <= 0;
    end
  endtask

  // usually clear, load a batch of tasks, then send a run of ticks
  task automatic run_round();
    int n_tasks;
    int pr_max;
    int arr_max;
    int run_len;
    int unsigned pick;
    logic [pps_pkg::ARR_W-1:0] arr;
    logic [pps_pkg::BURST_W-1:0] bst;
    logic [pps_pkg::PRIO_W-1:0] pr;
    n_tasks = ($urandom_range(7) == 0) ?
              $urandom_range(pps_pkg::MAX_TASKS_DEF + 1, pps_pkg::MAX_TASKS_DEF + 3) :
              $urandom_range(1, pps_pkg::MAX_TASKS_DEF);
    case ($urandom_range(2))
      0: pr_max = 1;
      1: pr_max = 7;
      default: pr_max = 255;
    endcase
    arr_max = $urandom_range(0, 24);
    run_len = 0;
    if ($urandom_range(9) != 0) send_clear();
    for (int k = 0; k < n_tasks; k++) begin
      pick = ($urandom_range(15) == 0) ? $urandom_range(65535) : $urandom_range(arr_max);
      arr = pick[pps_pkg::ARR_W-1:0];
      pick = ($urandom_range(15) == 0) ? $urandom_range(1, 65535) : $urandom_range(1, 6);
      bst = pick[pps_pkg::BURST_W-1:0];
      pick = $urandom_range(pr_max);
      pr = pick[pps_pkg::PRIO_W-1:0];
      if (bst <= 6) run_len += bst;
      send_request(pps_pkg::MODE_LOAD, arr, bst, pr);
      if ($urandom_range(19) == 0) send_random(MODE_UNUSED);
    end
    run_len += arr_max + $urandom_range(1, 4);
    if ($urandom_range(11) == 0) run_len = run_len / 2;
    for (int k = 0; k < run_len; k++) begin
      send_tick();
      if ($urandom_range(199) == 0) send_clear();
    end
  endtask

  initial begin
    int rounds;
    rounds = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // empty table, unused mode, priority and arrival order, never-arriving task
    send_tick();
    send_request(MODE_UNUSED, 16'hFFFF, 16'hFFFF, 8'hFF);
    send_request(pps_pkg::MODE_LOAD, 16'd0, 16'd1, 8'd255);
    send_request(pps_pkg::MODE_LOAD, 16'd0, 16'd2, 8'd0);
    send_request(pps_pkg::MODE_LOAD, 16'd1, 16'd1, 8'd0);
    send_request(pps_pkg::MODE_LOAD, 16'hFFFF, 16'hFFFF, 8'd0);
    repeat (5) send_tick();
    // zero burst task stays pending forever
    send_clear();
    send_request(pps_pkg::MODE_LOAD, 16'd0, 16'd0, 8'd0);
    send_request(pps_pkg::MODE_LOAD, 16'd0, 16'd1, 8'd0);
    send_tick();
    // full tie goes to the lower slot
    send_clear();
    send_request(pps_pkg::MODE_LOAD, 16'd0, 16'd1, 8'd7);
    send_request(pps_pkg::MODE_LOAD, 16'd0, 16'd1, 8'd7);
    repeat (2) send_tick();
    drain();

    // long receiver hold-off while requests keep coming
    hold_requests <= hold_requests + 1;
    while (sent_items < RANDOM_ITEMS) begin
      set_idle_mix();
      if (rounds % 5 == 4) drain();
      run_round();
      rounds++;
    end
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("%0d requests: %0d loads, %0d ticks, %0d clears, %0d unused-mode, %0d rounds",
             sb.n_load + sb.n_tick + sb.n_clear + sb.n_other, sb.n_load, sb.n_tick,
             sb.n_clear, sb.n_other, rounds);
    $display("%0d tick reports checked, %0d task completions, full table and long hold-off",
             sb.n_checked, sb.n_finished);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[files.f]
sv/pps_pkg.sv
sv/preemptive_priority_scheduler.sv
bench/tb.sv
